@@ rtl/sha1_pkg.sv @@
package sha1_pkg;

  localparam int unsigned NumWords = 5;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [6:0]  rnd_t;
  typedef logic [6:0]  fill_t;
  typedef logic [60:0] count_t;
  typedef logic [2:0]  widx_t;

  localparam rnd_t  LastRound  = 7'd79;
  localparam rnd_t  SchedStart = 7'd16;
  localparam fill_t FillFull   = 7'd64;
  localparam fill_t FillLast   = 7'd63;
  localparam fill_t FillLen    = 7'd56;
  localparam widx_t LastWord   = 3'd4;
  localparam byte_t PadMark    = 8'h80;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } sha1_abcde_t;

  typedef enum logic [2:0] {
    StIdle,
    StComp,
    StAdd,
    StPad,
    StOut
  } sha1_state_e;

  function automatic word_t iv(widx_t i);
    word_t r;
    case (i)
      3'd0:    r = 32'h67452301;
      3'd1:    r = 32'hEFCDAB89;
      3'd2:    r = 32'h98BADCFE;
      3'd3:    r = 32'h10325476;
      default: r = 32'hC3D2E1F0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/sha1_if.sv @@
interface sha1_in_if import sha1_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  has_byte;
  logic  end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if import sha1_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sha1_message_digest_top.sv @@
// channel | dir | payload                                  | handshake
// in_i    | in  | data_byte[7:0], has_byte, end_of_message | valid/ready
// out_o   | out | digest_word[31:0], word_index[2:0], last | valid/ready
//
// A byte item shifts into the block buffer; the 64th byte of a block also starts a compression
// (80 rounds through one shared round unit, then the chaining add).
// An end item pads one byte a cycle and writes the 64-bit bit length as one shift (padding may
// span two blocks), runs one or two compressions, then offers five digest words, one per
// cycle while out_o.ready is high.
// in_i.ready is low from the accept of a 64th byte or an end item until idle again.
// Reset is asynchronous and loads the initial vector; no clearing pass.
module sha1_message_digest_top import sha1_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);

  sha1_state_e state_q, state_d;
  fill_t       fill_q;
  count_t      cnt_q;
  logic        mark_q;
  logic        fin_q;
  logic        last_q;
  rnd_t        rnd_q;
  widx_t       oidx_q;
  word_t       h_q [NumWords];
  logic [511:0] win_q;
  sha1_abcde_t st_q;
  sha1_abcde_t st_nx;
  word_t       wi;
  logic        in_acc;
  logic        out_acc;
  logic        comp_start;
  logic        len_step;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign comp_start = (state_q != StComp) && (state_d == StComp);
  assign len_step   = (state_q == StPad) && mark_q && (fill_q == FillLen);

  sha1_round u_round (
    .rnd_i (rnd_q),
    .st_i  (st_q),
    .w0_i  (win_q[511:480]),
    .w2_i  (win_q[447:416]),
    .w8_i  (win_q[255:224]),
    .w13_i (win_q[95:64]),
    .w_o   (wi),
    .st_o  (st_nx)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.has_byte && (fill_q == FillLast)) begin
            state_d = StComp;
          end else if (in_i.end_of_message) begin
            state_d = StPad;
          end
        end
      end
      StComp: begin
        if (rnd_q == LastRound) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        if (last_q) begin
          state_d = StOut;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StPad: begin
        if (len_step || (fill_q == FillFull)) begin
          state_d = StComp;
        end
      end
      StOut: begin
        if (out_acc && (oidx_q == LastWord)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_i.ready        = (state_q == StIdle);
    out_o.valid       = (state_q == StOut);
    out_o.digest_word = h_q[oidx_q];
    out_o.word_index  = oidx_q;
    out_o.last_word   = (oidx_q == LastWord);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      cnt_q   <= '0;
      mark_q  <= 1'b0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      for (int i = 0; i < NumWords; i++) begin
        h_q[i] <= iv(widx_t'(i));
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            fin_q <= in_i.end_of_message;
            if (in_i.has_byte) begin
              fill_q <= fill_q + 7'd1;
              cnt_q  <= cnt_q + 61'd1;
            end
          end
        end
        StComp: begin
          rnd_q <= rnd_q + 7'd1;
        end
        StAdd: begin
          h_q[0] <= h_q[0] + st_q.a;
          h_q[1] <= h_q[1] + st_q.b;
          h_q[2] <= h_q[2] + st_q.c;
          h_q[3] <= h_q[3] + st_q.d;
          h_q[4] <= h_q[4] + st_q.e;
          fill_q <= '0;
          rnd_q  <= '0;
        end
        StPad: begin
          if (len_step) begin
            fill_q <= FillFull;
            last_q <= 1'b1;
          end else if (fill_q != FillFull) begin
            fill_q <= fill_q + 7'd1;
            mark_q <= 1'b1;
          end
        end
        StOut: begin
          if (out_acc) begin
            if (oidx_q == LastWord) begin
              oidx_q <= '0;
              cnt_q  <= '0;
              fill_q <= '0;
              mark_q <= 1'b0;
              fin_q  <= 1'b0;
              last_q <= 1'b0;
              for (int i = 0; i < NumWords; i++) begin
                h_q[i] <= iv(widx_t'(i));
              end
            end else begin
              oidx_q <= oidx_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && in_acc && in_i.has_byte) begin
      win_q <= {win_q[503:0], in_i.data_byte};
    end else if (len_step) begin
      win_q <= {win_q[447:0], cnt_q, 3'b000};
    end else if ((state_q == StPad) && (fill_q != FillFull)) begin
      win_q <= {win_q[503:0], (mark_q ? 8'h00 : PadMark)};
    end else if (state_q == StComp) begin
      win_q <= {win_q[479:0], wi};
    end
    if (comp_start) begin
      st_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
    end else if (state_q == StComp) begin
      st_q <= st_nx;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while digest is offered");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("buffer fill out of range");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StComp) |-> (rnd_q <= LastRound))
    else $error("round counter out of range");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_word) |=> (fill_q == '0) && (cnt_q == '0) && !mark_q)
    else $error("message state not cleared after digest");

endmodule

@@ rtl/sha1_round.sv @@
module sha1_round import sha1_pkg::*; (
  input  rnd_t        rnd_i,
  input  sha1_abcde_t st_i,
  input  word_t       w0_i,
  input  word_t       w2_i,
  input  word_t       w8_i,
  input  word_t       w13_i,
  output word_t       w_o,
  output sha1_abcde_t st_o
);

  word_t wx;
  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    wx  = w13_i ^ w8_i ^ w2_i ^ w0_i;
    w_o = (rnd_i < SchedStart) ? w0_i : {wx[30:0], wx[31]};
  end

  always_comb begin
    if (rnd_i inside {[7'd0:7'd19]}) begin
      f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      k = K0;
    end else if (rnd_i inside {[7'd20:7'd39]}) begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = K1;
    end else if (rnd_i inside {[7'd40:7'd59]}) begin
      f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
      k = K2;
    end else begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = K3;
    end
  end

  always_comb begin
    t      = {st_i.a[26:0], st_i.a[31:27]} + f + st_i.e + k + w_o;
    st_o.a = t;
    st_o.b = st_i.a;
    st_o.c = {st_i.b[1:0], st_i.b[31:2]};
    st_o.d = st_i.c;
    st_o.e = st_i.d;
  end

endmodule

@@ sim/sha1_message_digest_top_tb.sv @@
`timescale 1ns / 1ps

module sha1_message_digest_top_tb import sha1_pkg::*; ();

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned PhaseItems   = 30;
  localparam int unsigned PhaseMsgs    = 2;

  localparam word_t ShaIv0 = 32'h67452301;
  localparam word_t ShaIv1 = 32'hEFCDAB89;
  localparam word_t ShaIv2 = 32'h98BADCFE;
  localparam word_t ShaIv3 = 32'h10325476;
  localparam word_t ShaIv4 = 32'hC3D2E1F0;

  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;

  localparam byte_t PadByte = 8'h80;

  typedef struct packed {
    word_t word_val;
    widx_t word_idx;
    logic  is_last;
  } digest_item_t;

  class digest_scoreboard;
    word_t          chain[NumWords];
    byte_t          blk[64];
    int unsigned    fill;
    count_t         nbytes;
    digest_item_t   digest_q[$];
    int unsigned    errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = ShaIv0;
      chain[1] = ShaIv1;
      chain[2] = ShaIv2;
      chain[3] = ShaIv3;
      chain[4] = ShaIv4;
      fill   = 0;
      nbytes = '0;
    endfunction

    function word_t rotl(word_t x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    function void sha1_compress();
      word_t w[16];
      word_t a, b, c, d, e, f, k, t, wi;
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          wi = w[r];
        end else begin
          wi = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
          w[r%16] = wi;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = RoundK0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = RoundK1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = RoundK2;
        end else begin
          f = b ^ c ^ d;
          k = RoundK3;
        end
        t = rotl(a, 5) + f + e + k + wi;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb_item(byte_t data, logic has, logic eom);
      int unsigned   idx;
      logic [63:0]   bit_len;
      digest_item_t  dw;
      if (has) begin
        blk[fill] = data;
        fill++;
        nbytes = nbytes + 1'b1;
        if (fill == 64) begin
          sha1_compress();
          fill = 0;
        end
      end
      if (!eom) return;
      bit_len = {nbytes, 3'b000};
      idx = fill;
      blk[idx] = PadByte;
      idx++;
      if (idx > 56) begin
        while (idx < 64) begin
          blk[idx] = 8'h00;
          idx++;
        end
        sha1_compress();
        idx = 0;
      end
      while (idx < 56) begin
        blk[idx] = 8'h00;
        idx++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      sha1_compress();
      for (int i = 0; i < NumWords; i++) begin
        dw.word_val = chain[i];
        dw.word_idx = widx_t'(i);
        dw.is_last  = (i == NumWords - 1);
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_digest_word(word_t word, widx_t idx, logic last);
      digest_item_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected digest word %h index %0d", word, idx));
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word_val)
        report($sformatf("word %0d: got %h, want %h", want.word_idx, word, want.word_val));
      if (idx !== want.word_idx)
        report($sformatf("word index: got %0d, want %0d", idx, want.word_idx));
      if (last !== want.is_last)
        report($sformatf("last flag at word %0d: got %b, want %b",
                         want.word_idx, last, want.is_last));
    endtask

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned cycles;

  digest_scoreboard sb = new();

  sha1_in_if  in_if();
  sha1_out_if out_if();

  sha1_message_digest_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sha1_message_digest_top_tb: errors");
      $finish;
    end else if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_digest_word(out_if.digest_word, out_if.word_index, out_if.last_word);
    end
  end

  task automatic send_msg_item(byte_t data, logic has, logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.has_byte       <= has;
    in_if.end_of_message <= eom;
    do @(posedge clk_i); while (!in_if.ready);
    sb.absorb_item(data, has, eom);
  endtask

  task automatic send_message(int unsigned len);
    logic join_end;
    join_end = (len != 0) && $urandom_range(1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_msg_item(byte_t'($urandom_range(255)), 1'b0, 1'b0);
      send_msg_item(byte_t'($urandom_range(255)), 1'b1, join_end && (i == len - 1));
    end
    if (!join_end) send_msg_item(byte_t'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct);
    int unsigned items;
    int unsigned msgs;
    int unsigned len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    items = 0;
    msgs  = 0;
    while (items < PhaseItems || msgs < PhaseMsgs) begin
      if ($urandom_range(9) < 7) begin
        len = $urandom_range(12);
      end else begin
        case ($urandom_range(5))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          default: len = 65;
        endcase
      end
      send_message(len);
      items += len + 1;
      msgs++;
    end
    drain_digests();
  endtask

  initial begin
    cycles               = 0;
    src_idle_pct         = 21;
    snk_idle_pct         = 73;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.has_byte       = 1'b0;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_msg_item(8'h5A, 1'b0, 1'b1);
    send_msg_item(8'hFF, 1'b0, 1'b0);
    send_msg_item(8'hFF, 1'b1, 1'b1);
    send_msg_item(8'h00, 1'b1, 1'b1);
    send_msg_item(8'h61, 1'b1, 1'b0);
    send_msg_item(8'h62, 1'b1, 1'b0);
    send_msg_item(8'h63, 1'b1, 1'b0);
    send_msg_item(8'hFF, 1'b0, 1'b1);
    send_msg_item(8'h80, 1'b1, 1'b0);
    send_msg_item(8'h00, 1'b0, 1'b0);
    send_msg_item(8'h7F, 1'b1, 1'b1);
    drain_digests();

    run_phase(21, 73);
    run_phase(73, 21);
    run_phase(0, 0);

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sha1_message_digest_top_tb: clean");
    end else begin
      $display("sha1_message_digest_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_round.sv
rtl/sha1_message_digest_top.sv
sim/sha1_message_digest_top_tb.sv
